// File: rtl/pwm_tone_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PWM tone sequencer
// Same-cycle and next-cycle implication checks on a clock with an active-low
// reset.
// ----------------------------------------------------------------------------
`ifndef PWM_TONE_SEQUENCER_UNIT_ASSERT_SVH
`define PWM_TONE_SEQUENCER_UNIT_ASSERT_SVH

// Hold cons in the same cycle as ante.
`define PTS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwm tone sequencer check failed");

// Hold cons in the cycle after ante.
`define PTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwm tone sequencer check failed");

`endif

// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Widths, codes, reset values and shared types of the PWM tone sequencer.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int CMD_W     = 2;
    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int SYSCLK_W  = 32;
    localparam int DIVR_W    = 17;   // divisor width of the shared divider
    localparam int CLKDIV_W  = 17;
    localparam int WRAP_W    = 16;
    localparam int LEVEL_W   = 15;
    localparam int ELAPSED_W = 17;
    localparam int TOTAL_W   = 2;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 56;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [SYSCLK_W-1:0] SYSCLK_RST = 32'd125000000;
    localparam logic [CLKDIV_W-1:0] CLKDIV_RST = 17'd1;
    localparam logic [WRAP_W-1:0]   WRAP_RST   = 16'hFFFF;
    localparam logic [WRAP_W-1:0]   WRAP_FLOOR = 16'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SINGLE = 2'd0,
        CMD_PAIR   = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_COUNT,
        ST_DIV_WRAP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [SYSCLK_W-1:0] dividend;
        logic [DIVR_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SYSCLK_W-1:0] quotient;
    } div_resp_t;

endpackage

// File: rtl/pts_divider.sv
// ----------------------------------------------------------------------------
// pts_divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module pts_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  pts_pkg::div_req_t   req,
    output pts_pkg::div_resp_t  resp
);
    import pts_pkg::*;

    localparam int CNT_W = $clog2(SYSCLK_W + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;
    logic [DIVR_W-1:0]   rem_reg;
    logic [SYSCLK_W-1:0] quo_reg;
    logic [DIVR_W-1:0]   dsr_reg;

    logic [DIVR_W:0]     rem_shift;
    logic [DIVR_W:0]     rem_sub;
    logic                fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[SYSCLK_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        fits      = rem_shift >= {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (req.start) begin
                cnt_reg <= CNT_W'(SYSCLK_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? rem_sub[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
            quo_reg <= {quo_reg[SYSCLK_W-2:0], fits};
        end
    end

    assign resp.done     = done_reg;
    assign resp.quotient = quo_reg;

endmodule

// File: rtl/pwm_tone_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pwm_tone_sequencer_unit
// Square-wave tone sequencer: keeps up to two tone segments, times them with
// millisecond ticks and computes divider, wrap and duty for each segment.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  s_        s_tvalid / s_tready    tuser: command; tdata: freqs and durations
//  m_        m_tvalid / m_tready    tdata: PWM settings and play status
//  cfg_      cfg_wen                cfg_wdata: system clock in hertz
//
//  A segment start with a nonzero frequency runs two 32-step divisions on one
//  shared restoring divider (sysclk / freq, then count / divider): the result
//  and s_tready both come back in the same cycle, out of ST_RESULT; no item is
//  taken meanwhile. Other items (stop, tick, silent segment) skip the divider.
//  Reset is synchronous, active low; the register returns to 125 MHz.
//  The output register holds a result until taken; a new item is accepted
//  meanwhile, and a finished result waits in ST_RESULT while the previous
//  result is still held and m_tready is low.
// ----------------------------------------------------------------------------
module pwm_tone_sequencer_unit #(
    parameter int QUEUE_DEPTH = pts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wen,
    input  logic [pts_pkg::SYSCLK_W-1:0]   cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] first_freq, [31:16] first_dur, [47:32] second_freq, [63:48] second_dur
    input  logic [pts_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [pts_pkg::S_TUSER_W-1:0]  s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] pwm_enabled, [17:1] clock_divider, [33:18] wrap_value,
    // [48:34] duty_level, [49] playing, [50] segment_index, [55:51] zero
    output logic [pts_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pts_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    // slot of the second segment; only used when the queue holds two
    localparam logic [IDX_W-1:0] SEC_IDX = (QUEUE_DEPTH > 1) ? IDX_W'(1) : '0;
    localparam logic [TOTAL_W-1:0] PAIR_TOTAL =
        (QUEUE_DEPTH > 1) ? TOTAL_W'(2) : TOTAL_W'(1);

    // ---------------- registers ----------------
    state_t                 state_reg, state_next;
    logic [SYSCLK_W-1:0]    sysclk_reg;
    logic                   active_reg, active_next;
    logic                   cur_seg_reg, cur_seg_next;
    logic [TOTAL_W-1:0]     seg_total_reg, seg_total_next;
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [CLKDIV_W-1:0]    clkdiv_reg, clkdiv_next;
    logic [WRAP_W-1:0]      wrap_reg, wrap_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic                   enable_reg, enable_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic [FREQ_W-1:0]      seg_freq_reg [QUEUE_DEPTH];
    logic [DUR_W-1:0]       seg_dur_reg  [QUEUE_DEPTH];

    // ---------------- item fields ----------------
    cmd_t                   cmd;
    logic [FREQ_W-1:0]      first_freq, second_freq;
    logic [DUR_W-1:0]       first_dur, second_dur;

    assign cmd         = cmd_t'(s_tuser);
    assign first_freq  = s_tdata[FREQ_W-1:0];
    assign first_dur   = s_tdata[FREQ_W +: DUR_W];
    assign second_freq = s_tdata[FREQ_W+DUR_W +: FREQ_W];
    assign second_dur  = s_tdata[2*FREQ_W+DUR_W +: DUR_W];

    // ---------------- decode ----------------
    logic                   s_accept;
    logic                   out_free;
    logic [IDX_W-1:0]       cur_idx;
    logic [ELAPSED_W-1:0]   elapsed_inc;
    logic                   seg_end;
    logic [TOTAL_W-1:0]     next_seg;
    logic                   begin_seg;      // item starts a segment
    logic                   begin_second;   // the started segment is the second
    logic                   halt_seg;       // item stops playback
    logic [FREQ_W-1:0]      begin_freq;
    logic                   need_div;
    logic                   wr_first, wr_second;

    div_req_t               div_req;
    div_resp_t              div_resp;
    logic [WRAP_W-1:0]      wrap_calc;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cur_idx      = cur_seg_reg ? SEC_IDX : '0;
        // saturate at the counter top
        elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);
        seg_end      = elapsed_inc >= ELAPSED_W'(seg_dur_reg[cur_idx]);
        next_seg     = {1'b0, cur_seg_reg} + TOTAL_W'(1);
        begin_seg    = 1'b0;
        begin_second = 1'b0;
        halt_seg     = 1'b0;
        begin_freq   = first_freq;
        wr_first     = 1'b0;
        wr_second    = 1'b0;
        case (cmd)
            CMD_SINGLE: begin
                wr_first  = 1'b1;
                begin_seg = 1'b1;
            end
            CMD_PAIR: begin
                wr_first  = 1'b1;
                wr_second = (QUEUE_DEPTH > 1);
                begin_seg = 1'b1;
            end
            CMD_STOP: begin
                halt_seg = 1'b1;
            end
            CMD_TICK: begin
                if (active_reg && seg_end) begin
                    if (next_seg < seg_total_reg) begin
                        begin_seg    = 1'b1;
                        begin_second = 1'b1;
                        begin_freq   = seg_freq_reg[SEC_IDX];
                    end else begin
                        halt_seg = 1'b1;
                    end
                end
            end
            default: begin
                halt_seg = 1'b0;
            end
        endcase
        need_div = begin_seg && (begin_freq != '0);
    end

    // ---------------- shared divider ----------------
    pts_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    // apply the floor of two to the second quotient
    assign wrap_calc = (div_resp.quotient < SYSCLK_W'(WRAP_FLOOR))
                     ? WRAP_FLOOR : div_resp.quotient[WRAP_W-1:0];

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = need_div ? ST_DIV_COUNT : ST_RESULT;
                end
            end
            ST_DIV_COUNT: begin
                if (div_resp.done) begin
                    state_next = ST_DIV_WRAP;
                end
            end
            ST_DIV_WRAP: begin
                if (div_resp.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        active_next    = active_reg;
        cur_seg_next   = cur_seg_reg;
        seg_total_next = seg_total_reg;
        elapsed_next   = elapsed_reg;
        clkdiv_next    = clkdiv_reg;
        wrap_next      = wrap_reg;
        level_next     = level_reg;
        enable_next    = enable_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sysclk_reg;
        div_req.divisor  = DIVR_W'(begin_freq);

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (wr_first) begin
                        seg_total_next = wr_second ? PAIR_TOTAL : TOTAL_W'(1);
                    end
                    if (cmd == CMD_TICK && active_reg) begin
                        elapsed_next = elapsed_inc;
                    end
                    if (begin_seg) begin
                        cur_seg_next = begin_second;
                        elapsed_next = '0;
                        active_next  = 1'b1;
                        if (begin_freq == '0) begin
                            // silent segment: drop the duty, keep the rest
                            level_next = '0;
                        end else begin
                            div_req.start = 1'b1;
                        end
                    end
                    if (halt_seg) begin
                        active_next    = 1'b0;
                        seg_total_next = '0;
                        level_next     = '0;
                        enable_next    = 1'b0;
                    end
                end
            end
            ST_DIV_COUNT: begin
                // divider = count / 65536 + 1, then wrap = count / divider
                div_req.dividend = div_resp.quotient;
                div_req.divisor  = DIVR_W'(div_resp.quotient[SYSCLK_W-1:16])
                                 + DIVR_W'(1);
                if (div_resp.done) begin
                    div_req.start = 1'b1;
                    clkdiv_next   = CLKDIV_W'(div_req.divisor);
                end
            end
            ST_DIV_WRAP: begin
                if (div_resp.done) begin
                    wrap_next   = wrap_calc;
                    level_next  = wrap_calc[WRAP_W-1:1];
                    enable_next = 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, cur_seg_reg, active_reg, level_reg,
                                     wrap_reg, clkdiv_reg, enable_reg};
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sysclk_reg    <= SYSCLK_RST;
            active_reg    <= 1'b0;
            cur_seg_reg   <= 1'b0;
            seg_total_reg <= '0;
            elapsed_reg   <= '0;
            clkdiv_reg    <= CLKDIV_RST;
            wrap_reg      <= WRAP_RST;
            level_reg     <= '0;
            enable_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wen) begin
                sysclk_reg <= cfg_wdata;
            end
            active_reg    <= active_next;
            cur_seg_reg   <= cur_seg_next;
            seg_total_reg <= seg_total_next;
            elapsed_reg   <= elapsed_next;
            clkdiv_reg    <= clkdiv_next;
            wrap_reg      <= wrap_next;
            level_reg     <= level_next;
            enable_reg    <= enable_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // segment store and output payload: no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_accept && wr_first) begin
            seg_freq_reg['0] <= first_freq;
            seg_dur_reg['0]  <= first_dur;
        end
        if (s_accept && wr_second) begin
            seg_freq_reg[SEC_IDX] <= second_freq;
            seg_dur_reg[SEC_IDX]  <= second_dur;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the PWM tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "pwm_tone_sequencer_unit_assert.svh"

module pts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pts_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pts_pkg::*;

    // a stalled result holds
    `PTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one item at a time: busy right after an accept
    `PTS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // duty is either silent or half of the wrap
    `PTS_ASSERT_NOW(a_duty_half, aclk, aresetn, m_tvalid, (m_tdata[48:34] == 15'd0) || (m_tdata[48:34] == m_tdata[33:19]))
    // divider nonzero, wrap at least two
    `PTS_ASSERT_NOW(a_div_wrap_range, aclk, aresetn, m_tvalid, (m_tdata[17:1] != 17'd0) && (m_tdata[33:19] != 15'd0))
    // counter off when nothing plays
    `PTS_ASSERT_NOW(a_idle_off, aclk, aresetn, m_tvalid && !m_tdata[49], !m_tdata[0])

endmodule

bind pwm_tone_sequencer_unit pts_checker u_pts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/pwm_tone_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// PWM tone sequencer testbench
// Drives tone, tone-pair, stop and millisecond-tick items into the sequencer.
// An in-bench model of the sequencer predicts the PWM settings returned for
// every item unless a typed directed row gives them; each returned item is
// compared field by field. The system clock setting is swept between phases,
// across both range limits. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module pwm_tone_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 80;   // longest item is a two-division tone start plus handoff
    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 6;
    localparam int REPORT_LIMIT    = 10;
    localparam int DIRECTED_ROWS   = 23;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [4:0]          pad;
        logic                seg;
        logic                playing;
        logic [LEVEL_W-1:0]  level;
        logic [WRAP_W-1:0]   wrap;
        logic [CLKDIV_W-1:0] div;
        logic                en;
    } pwm_result_t;

    // One directed item; want is used only where typed is set.
    typedef struct packed {
        cmd_t              cmd;
        logic [FREQ_W-1:0] f1;
        logic [DUR_W-1:0]  d1;
        logic [FREQ_W-1:0] f2;
        logic [DUR_W-1:0]  d2;
        logic              typed;
        pwm_result_t       want;
    } tone_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [SYSCLK_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // first_freq, first_dur, second_freq, second_dur
    logic [S_TUSER_W-1:0]  s_tuser   = '0;   // command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // enable, divider, wrap, duty, playing, segment

    pwm_tone_sequencer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Sequencer model: its own copy of the register and the tone state.
    // ------------------------------------------------------------------------
    logic [SYSCLK_W-1:0]  mdl_sysclk;
    logic                 mdl_active;
    logic                 mdl_seg;
    logic [TOTAL_W-1:0]   mdl_total;
    logic [FREQ_W-1:0]    mdl_freq [2];
    logic [DUR_W-1:0]     mdl_dur [2];
    logic [ELAPSED_W-1:0] mdl_elapsed;
    logic [CLKDIV_W-1:0]  mdl_div;
    logic [WRAP_W-1:0]    mdl_wrap;
    logic [LEVEL_W-1:0]   mdl_level;
    logic                 mdl_en;

    pwm_result_t pending_settings[$];   // settings still owed by the block

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int ticks_live   = 0;
    int segment_hops = 0;
    int clocks_tried = 1;
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    int rx_hold      = 0;

    task automatic tone_model_reset();
        mdl_sysclk  = SYSCLK_RST;
        mdl_active  = 1'b0;
        mdl_seg     = 1'b0;
        mdl_total   = '0;
        mdl_freq[0] = '0;
        mdl_freq[1] = '0;
        mdl_dur[0]  = '0;
        mdl_dur[1]  = '0;
        mdl_elapsed = '0;
        mdl_div     = CLKDIV_RST;
        mdl_wrap    = WRAP_RST;
        mdl_level   = '0;
        mdl_en      = 1'b0;
    endtask

    // Silence only drops the duty; a real pitch reloads divider, wrap and duty and sets the enable.
    task automatic set_tone_pitch(input logic [FREQ_W-1:0] freq);
        logic [31:0] count;
        logic [31:0] dv;
        logic [31:0] wr;
        if (freq == '0) begin
            mdl_level = '0;
        end else begin
            count = mdl_sysclk / {16'd0, freq};
            dv    = (count >> 16) + 32'd1;
            wr    = count / dv;
            if (wr < 32'd2) begin
                wr = 32'd2;
            end
            mdl_div   = dv[CLKDIV_W-1:0];
            mdl_wrap  = wr[WRAP_W-1:0];
            mdl_level = wr[LEVEL_W:1];
            mdl_en    = 1'b1;
        end
    endtask

    task automatic launch_segment(input int idx);
        mdl_seg     = idx[0];
        mdl_elapsed = '0;
        set_tone_pitch(mdl_freq[idx[0]]);
        mdl_active  = 1'b1;
    endtask

    task automatic silence_tone();
        mdl_active = 1'b0;
        mdl_total  = '0;
        mdl_level  = '0;
        mdl_en     = 1'b0;
    endtask

    task automatic tone_step(input cmd_t cmd, input logic [FREQ_W-1:0] f1,
                             input logic [DUR_W-1:0] d1, input logic [FREQ_W-1:0] f2,
                             input logic [DUR_W-1:0] d2);
        int nxt;
        case (cmd)
            CMD_SINGLE: begin
                mdl_freq[0] = f1;
                mdl_dur[0]  = d1;
                mdl_total   = 2'd1;
                launch_segment(0);
            end
            CMD_PAIR: begin
                mdl_freq[0] = f1;
                mdl_dur[0]  = d1;
                mdl_freq[1] = f2;
                mdl_dur[1]  = d2;
                mdl_total   = 2'd2;
                launch_segment(0);
            end
            CMD_STOP: begin
                silence_tone();
            end
            default: begin
                if (mdl_active) begin
                    ticks_live++;
                    if (mdl_elapsed != '1) begin
                        mdl_elapsed = mdl_elapsed + ELAPSED_W'(1);
                    end
                    // segment ends once elapsed time reaches its duration
                    if (mdl_elapsed >= {1'b0, mdl_dur[mdl_seg]}) begin
                        nxt = int'(mdl_seg) + 1;
                        if (nxt < int'(mdl_total)) begin
                            segment_hops++;
                            launch_segment(nxt);
                        end else begin
                            silence_tone();
                        end
                    end
                end
            end
        endcase
    endtask

    function automatic pwm_result_t tone_result(input logic en, input logic [CLKDIV_W-1:0] div,
                                                input logic [WRAP_W-1:0] wrap,
                                                input logic [LEVEL_W-1:0] level,
                                                input logic playing, input logic seg);
        pwm_result_t r;
        r.pad     = '0;
        r.seg     = seg;
        r.playing = playing;
        r.level   = level;
        r.wrap    = wrap;
        r.div     = div;
        r.en      = en;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths: mostly short, a few long.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side at random; quiet stretches keep tready high.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_hold = pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0) begin
            rx_quiet = !rx_quiet;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken item with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        pwm_result_t got;
        pwm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = pwm_result_t'(m_tdata);
            results_seen++;
            if (pending_settings.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: unexpected result item %h", $realtime, got);
                end
            end else begin
                want = pending_settings.pop_front();
                if (got.en !== want.en || got.div !== want.div || got.wrap !== want.wrap ||
                    got.level !== want.level || got.playing !== want.playing ||
                    got.seg !== want.seg || got.pad !== want.pad) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("  expected en=%0d div=%0d wrap=%0d duty=%0d play=%0d seg=%0d pad=%0h",
                                 want.en, want.div, want.wrap, want.level, want.playing,
                                 want.seg, want.pad);
                        $display("  actual   en=%0d div=%0d wrap=%0d duty=%0d play=%0d seg=%0d pad=%0h",
                                 got.en, got.div, got.wrap, got.level, got.playing,
                                 got.seg, got.pad);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------------

    // Present one item, hold it until taken, predict, then maybe idle.
    task automatic send_tone_item(input cmd_t cmd, input logic [FREQ_W-1:0] f1,
                                  input logic [DUR_W-1:0] d1, input logic [FREQ_W-1:0] f2,
                                  input logic [DUR_W-1:0] d2, input logic typed,
                                  input pwm_result_t want);
        s_tuser  <= cmd;
        s_tdata  <= {d2, f2, d1, f1};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tone_step(cmd, f1, d1, f2, d2);
        pending_settings.push_back(typed ? want : tone_result(mdl_en, mdl_div, mdl_wrap,
                                                              mdl_level, mdl_active, mdl_seg));
        items_sent++;
        if (!tx_quiet && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
        if ($urandom_range(0, 49) == 0) begin
            tx_quiet = !tx_quiet;
        end
    endtask

    // Hold off the sender until every owed result is back, then let it settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_settings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sysclk(input logic [SYSCLK_W-1:0] hz);
        cfg_wdata <= hz;
        cfg_wen   <= 1'b1;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        mdl_sysclk = hz;
        clocks_tried++;
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end else if (r == 2) begin
            return FREQ_W'($urandom_range(1, 20));
        end
        return FREQ_W'($urandom);
    endfunction

    function automatic logic [DUR_W-1:0] pick_dur();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return DUR_W'($urandom_range(0, 5));
        end else if (r < 9) begin
            return DUR_W'($urandom_range(6, 40));
        end
        return DUR_W'($urandom);
    endfunction

    // Mostly tone starts followed by ticks that walk them through; stops and
    // restarts mid-segment break the sequences. Unused fields carry noise.
    function automatic cmd_t pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (!mdl_active) begin
            if (r < 40) return CMD_SINGLE;
            if (r < 80) return CMD_PAIR;
            if (r < 88) return CMD_STOP;
            return CMD_TICK;
        end
        if (r < 65) return CMD_TICK;
        if (r < 75) return CMD_SINGLE;
        if (r < 88) return CMD_PAIR;
        return CMD_STOP;
    endfunction

    tone_row_t   dir_rows [DIRECTED_ROWS];
    logic [SYSCLK_W-1:0] clock_plan [PHASES];

    initial begin
        pwm_result_t idle_rst;
        cmd_t        cmd;
        logic [FREQ_W-1:0] f1;
        logic [FREQ_W-1:0] f2;
        logic [DUR_W-1:0]  d1;
        logic [DUR_W-1:0]  d2;
        int          counted;

        tone_model_reset();
        idle_rst = tone_result(1'b0, CLKDIV_RST, WRAP_RST, '0, 1'b0, 1'b0);

        // Directed items at the 125 MHz reset clock.
        dir_rows = '{
            // idle tick and idle stop leave the reset settings
            '{CMD_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, idle_rst},
            '{CMD_STOP,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, idle_rst},
            // silent tone: plays but keeps divider, wrap and enable
            '{CMD_SINGLE, 16'd0,    16'd3,    16'd0,    16'd0,    1'b1,
              tone_result(1'b0, CLKDIV_RST, WRAP_RST, '0, 1'b1, 1'b0)},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b1, idle_rst},
            // top frequency, zero duration ends on the first tick
            '{CMD_SINGLE, 16'hFFFF, 16'd0,    16'd0,    16'd0,    1'b1,
              tone_result(1'b1, 17'd1, 16'd1907, 15'd953, 1'b1, 1'b0)},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b1,
              tone_result(1'b0, 17'd1, 16'd1907, 15'd0, 1'b0, 1'b0)},
            // lowest pitch, longest duration, then stop
            '{CMD_SINGLE, 16'd1,    16'hFFFF, 16'd0,    16'd0,    1'b0, '0},
            '{CMD_STOP,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            // pair: advance to segment one, then halt keeping the index
            '{CMD_PAIR,   16'd440,  16'd1,    16'd880,  16'd2,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            // silent second segment keeps the enable of the first
            '{CMD_PAIR,   16'd1000, 16'd0,    16'd0,    16'hFFFF, 1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_STOP,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_SINGLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
            '{CMD_PAIR,   16'd0,    16'd1,    16'hFFFF, 16'd0,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_TICK,   16'd0,    16'd0,    16'd0,    16'd0,    1'b0, '0},
            '{CMD_PAIR,   16'hFFFF, 16'hFFFF, 16'd1,    16'hFFFF, 1'b0, '0},
            '{CMD_STOP,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0}
        };

        clock_plan[0] = SYSCLK_RST;            // reset value, not written
        clock_plan[1] = 32'd1_000_000;
        clock_plan[2] = 32'hFFFF_FFFF;
        clock_plan[3] = $urandom_range(32'hFFFF_FFFF, 32'd1_000_000);
        clock_plan[4] = 32'd12_000_000;
        clock_plan[5] = SYSCLK_RST;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_tone_item(dir_rows[i].cmd, dir_rows[i].f1, dir_rows[i].d1, dir_rows[i].f2,
                           dir_rows[i].d2, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                write_sysclk(clock_plan[p]);
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                cmd = pick_cmd();
                if (cmd == CMD_TICK || cmd == CMD_STOP) begin
                    f1 = FREQ_W'($urandom);
                    d1 = DUR_W'($urandom);
                    f2 = FREQ_W'($urandom);
                    d2 = DUR_W'($urandom);
                end else begin
                    f1 = pick_freq();
                    d1 = pick_dur();
                    f2 = (cmd == CMD_PAIR) ? pick_freq() : FREQ_W'($urandom);
                    d2 = (cmd == CMD_PAIR) ? pick_dur() : DUR_W'($urandom);
                end
                // an idle tick changes nothing, so do not count it
                if (!(cmd == CMD_TICK && !mdl_active)) begin
                    counted++;
                end
                send_tone_item(cmd, f1, d1, f2, d2, 1'b0, '0);
                if ($urandom_range(0, 299) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end

        $display("Sent %0d items over %0d clock settings; %0d results checked, %0d errors.",
                 items_sent, clocks_tried, results_seen, errors);
        $display("Live ticks: %0d, moves to the second segment: %0d.", ticks_live, segment_hops);
        if (errors == 0 && pending_settings.size() == 0) begin
            $display("[pwm_tone_sequencer_unit] OK");
        end else begin
            $display("[pwm_tone_sequencer_unit] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10ms;
        $display("Timeout with %0d results still owed.", pending_settings.size());
        $display("[pwm_tone_sequencer_unit] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_divider.sv
rtl/pwm_tone_sequencer_unit.sv
rtl/pts_checker.sv
tb/pwm_tone_sequencer_unit_tb.sv
